// ----- rtl/mst_pkg.sv -----
// Shared types, constants and case tables of the marching-squares triangulator.
// No dependencies; mst_if.sv and the core in rtl/ use this package.
`default_nettype none

package mst_pkg;

  // Fixed field widths
  localparam int FIELD_W     = 16;
  localparam int COORD_W     = 18;
  localparam int CFG_W       = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int COL_IDX_W   = 10;
  localparam int CASE_CNT_W  = 4;

  localparam int COLUMN_COUNT_LIMIT    = 1024;
  localparam int DEF_MAX_COLUMN_LENGTH = 1024;
  localparam int DEF_FRACTION_BITS     = 8;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ISO_LEVEL     = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0]   RST_COLUMN_LENGTH = 11'd64;
  localparam logic [CFG_W-1:0]   RST_COLUMN_COUNT  = 11'd64;
  localparam logic [FIELD_W-1:0] RST_ISO_LEVEL     = 16'd256;

  // Cell edges, in the order the crossing unit visits them
  localparam logic [1:0] EDGE_S = 2'd0;
  localparam logic [1:0] EDGE_W = 2'd1;
  localparam logic [1:0] EDGE_E = 2'd2;
  localparam logic [1:0] EDGE_N = 2'd3;

  typedef enum logic [2:0] {
    P_SW, P_S, P_SE, P_E, P_NE, P_N, P_NW, P_W
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EDGE, ST_DIV, ST_EMIT
  } state_t;

  // Vertex count of each case
  localparam logic [CASE_CNT_W-1:0] CASE_LEN [16] = '{
    4'd0, 4'd3, 4'd3, 4'd6, 4'd3, 4'd12, 4'd6, 4'd9,
    4'd3, 4'd6, 4'd12, 4'd9, 4'd6, 4'd9, 4'd9, 4'd6
  };

  // Triangle vertex list of each case, padded to 12 entries
  localparam point_t CASE_PTS [16][12] = '{
    '{P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_W,  P_S,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_SE, P_S,  P_E,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_E,  P_W,  P_SW, P_E,  P_SE, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_NE, P_E,  P_N,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_SW, P_W,  P_S,  P_W,  P_N,  P_S,  P_S,  P_E,  P_N,  P_NE, P_N,  P_E },
    '{P_N,  P_S,  P_NE, P_NE, P_SE, P_S,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_W,  P_SW, P_SE, P_W,  P_N,  P_SE, P_N,  P_NE, P_SE, P_SW, P_SW, P_SW},
    '{P_NW, P_W,  P_N,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_N,  P_S,  P_NW, P_NW, P_SW, P_S,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_NW, P_N,  P_W,  P_N,  P_W,  P_S,  P_S,  P_E,  P_N,  P_SE, P_S,  P_E },
    '{P_NW, P_SW, P_N,  P_SW, P_N,  P_E,  P_SW, P_E,  P_SE, P_SW, P_SW, P_SW},
    '{P_E,  P_W,  P_NE, P_NW, P_NE, P_W,  P_SW, P_SW, P_SW, P_SW, P_SW, P_SW},
    '{P_NE, P_E,  P_NW, P_NW, P_E,  P_S,  P_S,  P_SW, P_NW, P_SW, P_SW, P_SW},
    '{P_NE, P_NW, P_W,  P_NE, P_W,  P_S,  P_S,  P_NE, P_SE, P_SW, P_SW, P_SW},
    '{P_NE, P_NW, P_SE, P_SE, P_SW, P_NW, P_SW, P_SW, P_SW, P_SW, P_SW, P_SW}
  };

endpackage

`default_nettype wire

// ----- rtl/mst_if.sv -----
// Valid/ready channels of the triangulator: sample words in, vertex words out.
// Depends on mst_pkg for field widths.
`default_nettype none

interface mst_field_if;
  logic                        valid;
  logic                        ready;
  logic [mst_pkg::FIELD_W-1:0] field_value;

  modport source (output valid, output field_value, input ready);
  modport sink   (input valid, input field_value, output ready);
endinterface

interface mst_vertex_if;
  logic                        valid;
  logic                        ready;
  logic [mst_pkg::COORD_W-1:0] vertex_x;
  logic [mst_pkg::COORD_W-1:0] vertex_y;
  logic                        last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/mst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/marching_squares_triangulator_core.sv -----
// Marching-squares triangulator top level: line buffer, cell case, crossing divider, emitter.
// Depends on mst_pkg, mst_if.sv (channel interfaces) and mst_ram.
//
//   channel    dir  word                                  notes
//   samples    in   field_value[15:0]                     column-major grid samples
//   vertices   out  vertex_x[17:0] vertex_y[17:0] last    one word per triangle vertex
//   cfg        in   cfg_write, cfg_index[1:0], cfg_data   length, count, iso level
//
// A sample is accepted (ST_IDLE) and the line buffer read and written (ST_READ); a closed
// cell with vertices walks its edges (ST_EDGE), runs the bit-serial restoring divider
// (ST_DIV) on each edge whose corners straddle the iso level and emits one vertex per cycle.
// The output register lets the next sample in while the last vertex waits.
// Reset is synchronous; the line buffer is not cleared. A stalled output holds the emitter.
`default_nettype none

module marching_squares_triangulator_core #(
  parameter int MAX_COLUMN_LENGTH = mst_pkg::DEF_MAX_COLUMN_LENGTH,
  parameter int FRACTION_BITS     = mst_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [mst_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mst_pkg::CFG_DATA_W-1:0]   cfg_data,
  mst_field_if.sink                             samples,
  mst_vertex_if.source                          vertices
);

  import mst_pkg::*;

  localparam int RW     = $clog2(MAX_COLUMN_LENGTH);
  localparam int LEN_W  = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int OFF_W  = FRACTION_BITS + 1;
  localparam int DCNT_W = $clog2(FRACTION_BITS + 1);
  localparam int REM_W  = FIELD_W + 1;
  localparam logic [OFF_W-1:0]  HALF_OFF = OFF_W'(1) << (FRACTION_BITS - 1);
  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_COLUMN_LENGTH);
  localparam logic [CFG_W-1:0]  CNT_MAX  = CFG_W'(COLUMN_COUNT_LIMIT);

  state_t state, state_next;

  // Configuration registers
  logic [CFG_W-1:0]   column_length;
  logic [CFG_W-1:0]   column_count;
  logic [FIELD_W-1:0] iso_level;

  // Grid position and neighbor samples
  logic [RW-1:0]        row_index;
  logic [COL_IDX_W-1:0] column_index;
  logic [FIELD_W-1:0]   below_sample;
  logic [FIELD_W-1:0]   below_prior_sample;
  logic [FIELD_W-1:0]   sample;

  // Cell under work
  logic [RW-1:0]         cell_row;
  logic [COL_IDX_W-1:0]  cell_col;
  logic [FIELD_W-1:0]    c_sw, c_se, c_ne, c_nw;
  logic [3:0]            case_code;
  logic [1:0]            edge_sel;
  logic [OFF_W-1:0]      offs [4];
  logic [CASE_CNT_W-1:0] k;

  // Divider
  logic [FIELD_W-1:0] den;
  logic [REM_W-1:0]   rem;
  logic [OFF_W-1:0]   quo;
  logic [DCNT_W-1:0]  dcnt;

  // Output register
  logic               out_valid;
  logic [COORD_W-1:0] out_x, out_y;
  logic               out_last;

  logic [FIELD_W-1:0] ram_rdata;

  // Line buffer: previous column
  mst_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (MAX_COLUMN_LENGTH)
  ) u_line (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (cell_row),
    .wdata (sample),
    .raddr (row_index),
    .rdata (ram_rdata)
  );

  // Clamped frame limits and index advance
  logic [LEN_W-1:0] len_c, row_plus;
  logic [CFG_W-1:0] cnt_c, col_plus;
  logic             row_wrap, col_wrap;

  always_comb begin
    if (column_length < CFG_W'(2)) begin
      len_c = LEN_W'(2);
    end else if (LEN_W'(column_length) > LEN_MAX) begin
      len_c = LEN_MAX;
    end else begin
      len_c = LEN_W'(column_length);
    end
    if (column_count < CFG_W'(2)) begin
      cnt_c = CFG_W'(2);
    end else if (column_count > CNT_MAX) begin
      cnt_c = CNT_MAX;
    end else begin
      cnt_c = column_count;
    end
    row_plus = LEN_W'(row_index) + LEN_W'(1);
    col_plus = CFG_W'(column_index) + CFG_W'(1);
    row_wrap = row_plus >= len_c;
    col_wrap = col_plus >= cnt_c;
  end

  // Corner classification at the read cycle
  logic [3:0] case_now;
  logic       is_cell;

  assign case_now = {ram_rdata >= iso_level, sample >= iso_level,
                     below_sample >= iso_level, below_prior_sample >= iso_level};
  assign is_cell  = (column_index != '0) && (row_index != '0);

  // Edge operand selection
  logic [FIELD_W-1:0] ea, eb, num;
  logic               ia, ib, straddle;

  always_comb begin
    case (edge_sel)
      EDGE_S: begin
        ea = c_sw; eb = c_se; ia = case_code[0]; ib = case_code[1];
      end
      EDGE_W: begin
        ea = c_sw; eb = c_nw; ia = case_code[0]; ib = case_code[3];
      end
      EDGE_E: begin
        ea = c_se; eb = c_ne; ia = case_code[1]; ib = case_code[2];
      end
      default: begin
        ea = c_nw; eb = c_ne; ia = case_code[3]; ib = case_code[2];
      end
    endcase
    straddle = ia != ib;
    num = (ea > iso_level) ? ea - iso_level : iso_level - ea;
  end

  // One restoring division step
  logic [REM_W-1:0] r_try, den_e;
  logic             qbit;

  always_comb begin
    den_e = REM_W'(den);
    r_try = (dcnt == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    qbit  = r_try >= den_e;
  end

  // Vertex coordinates
  logic [COORD_W-1:0] x0, x1, y0, y1, px, py;
  point_t             pt;
  logic               load, last_k;

  always_comb begin
    x0 = COORD_W'({COL_IDX_W'(cell_col - 1'b1), {FRACTION_BITS{1'b0}}});
    x1 = COORD_W'({cell_col, {FRACTION_BITS{1'b0}}});
    y0 = COORD_W'({RW'(cell_row - 1'b1), {FRACTION_BITS{1'b0}}});
    y1 = COORD_W'({cell_row, {FRACTION_BITS{1'b0}}});
    pt = CASE_PTS[case_code][k];
    case (pt)
      P_SW:    begin px = x0; py = y0; end
      P_SE:    begin px = x1; py = y0; end
      P_NE:    begin px = x1; py = y1; end
      P_NW:    begin px = x0; py = y1; end
      P_S:     begin px = x0 + COORD_W'(offs[EDGE_S]); py = y0; end
      P_W:     begin px = x0; py = y0 + COORD_W'(offs[EDGE_W]); end
      P_E:     begin px = x1; py = y0 + COORD_W'(offs[EDGE_E]); end
      default: begin px = x0 + COORD_W'(offs[EDGE_N]); py = y1; end
    endcase
    load   = (state == ST_EMIT) && (!out_valid || vertices.ready);
    last_k = k == CASE_LEN[case_code] - CASE_CNT_W'(1);
  end

  // Next state and handshake outputs
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (is_cell && CASE_LEN[case_now] != '0) state_next = ST_EDGE;
        else state_next = ST_IDLE;
      end
      ST_EDGE: begin
        if (straddle) state_next = ST_DIV;
        else if (edge_sel == EDGE_N) state_next = ST_EMIT;
      end
      ST_DIV: begin
        if (dcnt == DCNT_W'(FRACTION_BITS)) begin
          state_next = (edge_sel == EDGE_N) ? ST_EMIT : ST_EDGE;
        end
      end
      ST_EMIT: begin
        if (load && last_k) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign vertices.valid       = out_valid;
  assign vertices.vertex_x    = out_x;
  assign vertices.vertex_y    = out_y;
  assign vertices.last_vertex = out_last;

  // State register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      column_length      <= RST_COLUMN_LENGTH;
      column_count       <= RST_COLUMN_COUNT;
      iso_level          <= RST_ISO_LEVEL;
      row_index          <= '0;
      column_index       <= '0;
      below_sample       <= '0;
      below_prior_sample <= '0;
      out_valid          <= 1'b0;
      edge_sel           <= EDGE_S;
      dcnt               <= '0;
      k                  <= '0;
    end else begin
      state <= state_next;

      // Configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_COLUMN_LENGTH: column_length <= cfg_data[CFG_W-1:0];
          REG_COLUMN_COUNT:  column_count  <= cfg_data[CFG_W-1:0];
          REG_ISO_LEVEL:     iso_level     <= cfg_data;
          default: ;
        endcase
      end

      // Neighbor samples and grid advance
      if (state == ST_READ) begin
        below_prior_sample <= ram_rdata;
        below_sample       <= sample;
        edge_sel           <= EDGE_S;
        dcnt               <= '0;
        k                  <= '0;
        if (row_wrap) begin
          row_index    <= '0;
          column_index <= col_wrap ? '0 : COL_IDX_W'(col_plus);
        end else begin
          row_index <= RW'(row_plus);
        end
      end

      // Edge walk and divider count
      if (state == ST_EDGE && !straddle) begin
        edge_sel <= edge_sel + 2'd1;
      end
      if (state == ST_DIV) begin
        if (dcnt == DCNT_W'(FRACTION_BITS)) begin
          dcnt     <= '0;
          edge_sel <= edge_sel + 2'd1;
        end else begin
          dcnt <= dcnt + DCNT_W'(1);
        end
      end

      // Output register: a new vertex loads, an accepted one clears
      out_valid <= load || (out_valid && !vertices.ready);
      if (load) begin
        k <= k + CASE_CNT_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && samples.valid) begin
      sample   <= samples.field_value;
      cell_row <= row_index;
      cell_col <= column_index;
    end
    if (state == ST_READ) begin
      c_sw      <= below_prior_sample;
      c_se      <= below_sample;
      c_ne      <= sample;
      c_nw      <= ram_rdata;
      case_code <= case_now;
    end
    if (state == ST_EDGE) begin
      if (straddle) begin
        rem <= REM_W'(num);
        den <= (eb > ea) ? eb - ea : ea - eb;
        quo <= '0;
      end else begin
        offs[edge_sel] <= HALF_OFF;
      end
    end
    if (state == ST_DIV) begin
      rem <= qbit ? r_try - den_e : r_try;
      quo <= {quo[OFF_W-2:0], qbit};
      if (dcnt == DCNT_W'(FRACTION_BITS)) begin
        offs[edge_sel] <= {quo[OFF_W-2:0], qbit};
      end
    end
    if (load) begin
      out_x    <= px;
      out_y    <= py;
      out_last <= last_k;
    end
  end

endmodule

`default_nettype wire
